### design/cct_pkg.sv
package cct_pkg;

    // Width of the year counter; the year wraps at 2**YEAR_BITS.
    localparam int YEAR_BITS = 12;

    // Request function codes.
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    localparam logic [5:0] SEC_LAST   = 6'd59;
    localparam logic [5:0] MIN_LAST   = 6'd59;
    localparam logic [4:0] HOUR_LAST  = 5'd23;
    localparam logic [3:0] MONTH_LAST = 4'd12;

    // Multiplicative inverse of 25 modulo 2**16, cut to the year width. A year is a
    // multiple of 25 exactly when year * Inv25 (mod 2**YEAR_BITS) is at most Div25Max.
    localparam logic [YEAR_BITS-1:0] Inv25    = YEAR_BITS'(16'd23593);
    localparam logic [YEAR_BITS-1:0] Div25Max = YEAR_BITS'(((1 << YEAR_BITS) - 1) / 25);

    typedef struct packed {
        logic                 func;
        logic [5:0]           new_second;
        logic [5:0]           new_minute;
        logic [4:0]           new_hour;
        logic [4:0]           new_day;
        logic [3:0]           new_month;
        logic [YEAR_BITS-1:0] new_year;
    } t_in;

    typedef struct packed {
        logic [5:0]           cur_second;
        logic [5:0]           cur_minute;
        logic [4:0]           cur_hour;
        logic [4:0]           cur_day;
        logic [3:0]           cur_month;
        logic [YEAR_BITS-1:0] cur_year;
    } t_out;

    // Gregorian leap year: divisible by 4, and either not by 25 (so not by 100)
    // or by 16 (which together with 25 means by 400).
    function automatic logic is_leap(input logic [YEAR_BITS-1:0] year);
        logic [YEAR_BITS-1:0] prod;
        logic                 div25;
        prod  = YEAR_BITS'(year * Inv25);
        div25 = (prod <= Div25Max);
        return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
    endfunction

    // Days in a month; a month code outside 1 to 12 counts as 31 days.
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] days;
        case (month)
            4'd2:    days = leap ? 5'd29 : 5'd28;
            4'd4:    days = 5'd30;
            4'd6:    days = 5'd30;
            4'd9:    days = 5'd30;
            4'd11:   days = 5'd30;
            default: days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

### design/cct_advance.sv
module cct_advance
    import cct_pkg::*;
(
    input  t_out i_time,
    output t_out o_time
);

    logic       carry_sec;
    logic       carry_min;
    logic       carry_hour;
    logic       carry_day;
    logic       carry_month;
    logic [4:0] days;

    // Each carry ripples only when every lower field is at its last value or beyond.
    always_comb begin
        days        = month_days(i_time.cur_month, is_leap(i_time.cur_year));
        carry_sec   = (i_time.cur_second >= SEC_LAST);
        carry_min   = carry_sec && (i_time.cur_minute >= MIN_LAST);
        carry_hour  = carry_min && (i_time.cur_hour >= HOUR_LAST);
        carry_day   = carry_hour && (i_time.cur_day >= days);
        carry_month = carry_day && (i_time.cur_month >= MONTH_LAST);

        o_time = i_time;

        o_time.cur_second = carry_sec ? 6'd0 : i_time.cur_second + 6'd1;

        if (carry_sec) begin
            o_time.cur_minute = carry_min ? 6'd0 : i_time.cur_minute + 6'd1;
        end

        if (carry_min) begin
            o_time.cur_hour = carry_hour ? 5'd0 : i_time.cur_hour + 5'd1;
        end

        if (carry_hour) begin
            o_time.cur_day = carry_day ? 5'd1 : i_time.cur_day + 5'd1;
        end

        if (carry_day) begin
            o_time.cur_month = carry_month ? 4'd1 : i_time.cur_month + 4'd1;
        end

        if (carry_month) begin
            o_time.cur_year = i_time.cur_year + YEAR_BITS'(1);
        end
    end

endmodule

### design/calendar_clock_tick_top.sv
// Calendar clock: seconds, minutes, hours, day, month and year counters.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): each request is either
// a one-second tick (func = FUNC_TICK) or a load of the full time from the
// new_* fields (func = FUNC_LOAD). Loaded values are stored without a range
// check; a value above its range rolls over with a carry on a later tick.
// Output channel (o_out_valid / i_out_ready / o_out_data): every request
// returns exactly one result, the time as it stands after that request.
//
// A request's result is registered and shows in the cycle after the request
// is accepted. Throughput is one request per cycle while results are taken
// at once. The time counters form a single register, and the next time is
// worked out by one pass of carry logic (cct_advance) from that register.
// While a result waits, the held time is the result itself, so the input
// side stays ready as long as the result is taken in the same cycle; when
// the receiver stalls, o_in_ready drops until the result is taken.
// Reset sets the time to 00:00:00 on day 1 of month 1, year 0, and leaves
// no result pending.
module calendar_clock_tick_top
    import cct_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_out r_time;
    t_out n_time;
    t_out tick_time;
    logic r_valid;
    logic n_valid;
    logic in_fire;

    cct_advance u_advance (
        .i_time (r_time),
        .o_time (tick_time)
    );

    // A new request may enter when no result is held or the held one leaves now.
    assign o_in_ready = !r_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_time  = r_time;
        n_valid = r_valid && !i_out_ready;
        if (in_fire) begin
            n_valid = 1'b1;
            if (i_in_data.func == FUNC_LOAD) begin
                n_time.cur_second = i_in_data.new_second;
                n_time.cur_minute = i_in_data.new_minute;
                n_time.cur_hour   = i_in_data.new_hour;
                n_time.cur_day    = i_in_data.new_day;
                n_time.cur_month  = i_in_data.new_month;
                n_time.cur_year   = i_in_data.new_year;
            end else begin
                n_time = tick_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid           <= 1'b0;
            r_time.cur_second <= 6'd0;
            r_time.cur_minute <= 6'd0;
            r_time.cur_hour   <= 5'd0;
            r_time.cur_day    <= 5'd1;
            r_time.cur_month  <= 4'd1;
            r_time.cur_year   <= '0;
        end else begin
            r_valid <= n_valid;
            r_time  <= n_time;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_time;

    // Every accepted request leaves a result pending in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> o_out_valid)
    else $error("accepted request produced no result");

    // A load stores the request fields unchanged.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (i_in_data.func == FUNC_LOAD) |=>
            (o_out_data.cur_second == $past(i_in_data.new_second)) &&
            (o_out_data.cur_minute == $past(i_in_data.new_minute)) &&
            (o_out_data.cur_hour == $past(i_in_data.new_hour)) &&
            (o_out_data.cur_day == $past(i_in_data.new_day)) &&
            (o_out_data.cur_month == $past(i_in_data.new_month)) &&
            (o_out_data.cur_year == $past(i_in_data.new_year)))
    else $error("load did not store the requested time");

    // A tick with no seconds carry bumps the seconds and leaves the rest alone.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (i_in_data.func == FUNC_TICK) && (r_time.cur_second < SEC_LAST) |=>
            (r_time.cur_second == $past(r_time.cur_second) + 6'd1) &&
            $stable(r_time.cur_minute) && $stable(r_time.cur_hour) &&
            $stable(r_time.cur_day) && $stable(r_time.cur_month) &&
            $stable(r_time.cur_year))
    else $error("tick without carry changed more than the seconds");

    // The time changes only when a request is accepted.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_fire |=> $stable(r_time))
    else $error("time changed without a request");

endmodule

### sim/calendar_clock_tick_top_test.sv
`timescale 1ns / 1ps

module calendar_clock_tick_top_test;
    import cct_pkg::*;

    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int YEAR_SPAN    = 1 << YEAR_BITS;

    // Month lengths in an ordinary year, January first.
    localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    // These years sit on the leap rules and on the wrap of the year counter.
    localparam int EDGE_YEARS [10] = '{0, 100, 400, 1900, 2000, 2023, 2024, 2100, 4000, 4095};

    // Receiver behavior. It is chosen again after a run of random length.
    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_MOSTLY} t_sink_mode;

    // One row of the directed table. When has_want is set, the row carries its own
    // expected time. Otherwise the shadow counters supply the expected time.
    typedef struct {
        t_in  req;
        bit   has_want;
        t_out want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    t_row        directed_rows[$];
    t_out        expected_times[$];
    t_out        shadow_time;
    int          burst_left;
    int          mismatch_count;
    int          results_taken;
    int unsigned cycle_count;

    calendar_clock_tick_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog. Reaching CYCLE_LIMIT means that the handshake has hung somewhere.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_out time_val(int s, int m, int h, int d, int mo, int y);
        t_out t;
        t.cur_second = 6'(s);
        t.cur_minute = 6'(m);
        t.cur_hour   = 5'(h);
        t.cur_day    = 5'(d);
        t.cur_month  = 4'(mo);
        t.cur_year   = YEAR_BITS'(y);
        return t;
    endfunction

    function automatic t_in load_req(int s, int m, int h, int d, int mo, int y);
        t_in r;
        r.func       = FUNC_LOAD;
        r.new_second = 6'(s);
        r.new_minute = 6'(m);
        r.new_hour   = 5'(h);
        r.new_day    = 5'(d);
        r.new_month  = 4'(mo);
        r.new_year   = YEAR_BITS'(y);
        return r;
    endfunction

    // A tick must ignore the load fields, so they are filled with all zeros or all
    // ones to show that nothing of them leaks through.
    function automatic t_in tick_req(bit fill_ones);
        t_in r;
        r      = fill_ones ? '1 : '0;
        r.func = FUNC_TICK;
        return r;
    endfunction

    function automatic void add_row(t_in req, bit has_want, t_out want);
        t_row row;
        row.req      = req;
        row.has_want = has_want;
        row.want     = want;
        directed_rows.push_back(row);
    endfunction

    // Shadow calendar. A load takes its fields exactly as given. A tick runs the
    // carry chain from seconds up to the year. Each comparison uses "reached the
    // limit or beyond", so a loaded value above its range clears and carries.
    function automatic t_out time_after(t_out cur, t_in req);
        int sec;
        int mins;
        int hr;
        int dy;
        int mon;
        int yr;
        int mlen;
        if (req.func == FUNC_LOAD) begin
            return time_val(int'(req.new_second), int'(req.new_minute), int'(req.new_hour),
                            int'(req.new_day), int'(req.new_month), int'(req.new_year));
        end
        sec  = int'(cur.cur_second) + 1;
        mins = int'(cur.cur_minute);
        hr   = int'(cur.cur_hour);
        dy   = int'(cur.cur_day);
        mon  = int'(cur.cur_month);
        yr   = int'(cur.cur_year);
        if (sec >= 60) begin
            sec = 0;
            mins++;
            if (mins >= 60) begin
                mins = 0;
                hr++;
                if (hr >= 24) begin
                    hr = 0;
                    // A month code outside January to December counts as 31 days.
                    if (mon < 1 || mon > 12) begin
                        mlen = 31;
                    end else begin
                        mlen = MONTH_DAYS[mon - 1];
                        if (mon == 2 && ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0)) begin
                            mlen++;
                        end
                    end
                    if (dy < mlen) begin
                        dy++;
                    end else begin
                        dy = 1;
                        if (mon < 12) begin
                            mon++;
                        end else begin
                            mon = 1;
                            yr  = (yr + 1) % YEAR_SPAN;
                        end
                    end
                end
            end
        end
        return time_val(sec, mins, hr, dy, mon, yr);
    endfunction

    // Random loads lean toward a time just before midnight near a month end, so that
    // the following ticks run through the full carry chain. About one in ten is raw
    // noise over every bit of every field, out-of-range codes included.
    function automatic t_in random_load();
        t_in         r;
        logic [63:0] noise;
        if ($urandom_range(0, 9) == 0) begin
            noise  = {$urandom, $urandom};
            r      = noise[$bits(t_in)-1:0];
            r.func = FUNC_LOAD;
            return r;
        end
        r.func       = FUNC_LOAD;
        r.new_second = ($urandom_range(0, 2) != 0) ? 6'd59 : 6'($urandom_range(0, 59));
        r.new_minute = ($urandom_range(0, 2) != 0) ? 6'd59 : 6'($urandom_range(0, 59));
        r.new_hour   = ($urandom_range(0, 2) != 0) ? 5'd23 : 5'($urandom_range(0, 23));
        r.new_day    = ($urandom_range(0, 1) != 0) ? 5'($urandom_range(28, 31))
                                                   : 5'($urandom_range(1, 31));
        r.new_month  = 4'($urandom_range(1, 12));
        r.new_year   = ($urandom_range(0, 1) != 0) ? YEAR_BITS'(EDGE_YEARS[$urandom_range(0, 9)])
                                                   : YEAR_BITS'($urandom);
        return r;
    endfunction

    function automatic t_in random_tick();
        t_in         r;
        logic [63:0] noise;
        noise  = {$urandom, $urandom};
        r      = noise[$bits(t_in)-1:0];
        r.func = FUNC_TICK;
        return r;
    endfunction

    // Offers one request and returns at the edge where it is taken. The sender
    // works in bursts. Before each burst it may leave the channel idle. The
    // expected time is queued at the edge of acceptance, before the result can
    // reach the sink.
    task automatic send_request(t_in req, bit has_want, t_out want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        shadow_time = time_after(shadow_time, req);
        expected_times.push_back(has_want ? want : shadow_time);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result(t_out got);
        t_out want;
        results_taken++;
        if (expected_times.size() == 0) begin
            $display("%0t: result with no request pending, expected none, got %0d:%0d:%0d %0d/%0d/%0d",
                     $time, got.cur_hour, got.cur_minute, got.cur_second,
                     got.cur_day, got.cur_month, got.cur_year);
            mismatch_count++;
            return;
        end
        want = expected_times.pop_front();
        check_field("second", int'(want.cur_second), int'(got.cur_second));
        check_field("minute", int'(want.cur_minute), int'(got.cur_minute));
        check_field("hour",   int'(want.cur_hour),   int'(got.cur_hour));
        check_field("day",    int'(want.cur_day),    int'(got.cur_day));
        check_field("month",  int'(want.cur_month),  int'(got.cur_month));
        check_field("year",   int'(want.cur_year),   int'(got.cur_year));
    endtask

    // Result side. Outputs are sampled at the rising edge, before the block
    // updates, and ready is driven for the next cycle. The stall pattern changes
    // after a run of random length. One long hold-off lets the single result slot
    // fill, so the input side must stall while the sender keeps offering requests.
    initial begin : result_sink
        t_sink_mode mode;
        int         phase;
        int         hold_left;
        bit         hold_done;
        bit         ready_next;
        mode        = SINK_OPEN;
        phase       = 0;
        hold_left   = 0;
        hold_done   = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                check_result(o_out_data);
            end
            if (phase == 0) begin
                mode  = t_sink_mode'($urandom_range(0, 3));
                phase = $urandom_range(16, 64);
            end
            phase--;
            if (!hold_done && results_taken == 300) begin
                hold_done = 1'b1;
                hold_left = 200;
            end
            case (mode)
                SINK_OPEN:   ready_next = 1'b1;
                SINK_COIN:   ready_next = ($urandom_range(0, 1) != 0);
                SINK_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
                default:     ready_next = ($urandom_range(0, 7) != 0);
            endcase
            if (hold_left != 0) begin
                ready_next = 1'b0;
                hold_left--;
            end
            i_out_ready <= ready_next;
        end
    end

    // Request side and the end of the run.
    initial begin : request_source
        int random_sent;
        int tick_run;
        bit drained;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        burst_left     = 0;
        mismatch_count = 0;
        results_taken  = 0;
        random_sent    = 0;
        drained        = 1'b0;
        shadow_time    = time_val(0, 0, 0, 1, 1, 0);

        // The directed rows come first. They cover the reset state, loads of the
        // smallest and largest field values, the full wrap at the end of the last
        // year, the leap rules for years divisible by 4, by 100 and by 400, and the
        // end of a 30-day month. They also cover day zero, month zero and other values
        // that are out of range, and a tick whose load fields are all ones.
        add_row(tick_req(1'b0), 1'b1, time_val(1, 0, 0, 1, 1, 0));
        add_row(load_req(0, 0, 0, 0, 0, 0), 1'b1, time_val(0, 0, 0, 0, 0, 0));
        add_row(tick_req(1'b1), 1'b0, '0);
        add_row(load_req(63, 63, 31, 31, 15, 4095), 1'b1, time_val(63, 63, 31, 31, 15, 4095));
        add_row(tick_req(1'b0), 1'b1, time_val(0, 0, 0, 1, 1, 0));
        add_row(load_req(59, 59, 23, 31, 12, 4095), 1'b1, time_val(59, 59, 23, 31, 12, 4095));
        add_row(tick_req(1'b0), 1'b1, time_val(0, 0, 0, 1, 1, 0));
        add_row(load_req(59, 10, 5, 7, 3, 1234), 1'b0, '0);
        add_row(tick_req(1'b1), 1'b0, '0);
        add_row(load_req(59, 59, 23, 28, 2, 1900), 1'b0, '0);
        add_row(tick_req(1'b0), 1'b0, '0);
        add_row(load_req(59, 59, 23, 28, 2, 2000), 1'b0, '0);
        add_row(tick_req(1'b0), 1'b0, '0);
        add_row(load_req(59, 59, 23, 29, 2, 2024), 1'b0, '0);
        add_row(tick_req(1'b0), 1'b0, '0);
        add_row(load_req(59, 59, 23, 28, 2, 2023), 1'b0, '0);
        add_row(tick_req(1'b1), 1'b0, '0);
        add_row(load_req(59, 59, 23, 30, 4, 2022), 1'b0, '0);
        add_row(tick_req(1'b0), 1'b0, '0);
        add_row(load_req(59, 59, 23, 0, 0, 77), 1'b0, '0);
        add_row(tick_req(1'b0), 1'b0, '0);
        add_row(load_req(59, 59, 23, 31, 0, 77), 1'b0, '0);
        add_row(tick_req(1'b0), 1'b0, '0);
        add_row(load_req(59, 59, 23, 31, 12, 2023), 1'b0, '0);
        add_row(tick_req(1'b0), 1'b0, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].has_want, directed_rows[i].want);
        end

        // Random sequences: a load close to a rollover, then a run of ticks. Most
        // runs are short. Some are long enough to carry the seconds into the minutes
        // on their own.
        while (random_sent < RANDOM_ITEMS) begin
            send_request(random_load(), 1'b0, '0);
            random_sent++;
            tick_run = ($urandom_range(0, 6) == 0) ? $urandom_range(20, 130)
                                                   : $urandom_range(0, 6);
            for (int k = 0; k < tick_run && random_sent < RANDOM_ITEMS; k++) begin
                send_request(random_tick(), 1'b0, '0);
                random_sent++;
            end
            // Halfway through, the sender goes quiet until every result has come
            // back, so the block runs empty once with requests still to come.
            if (!drained && random_sent >= RANDOM_ITEMS / 2) begin
                drained    = 1'b1;
                i_in_valid <= 1'b0;
                while (expected_times.size() != 0) @(posedge i_clk);
            end
        end

        i_in_valid <= 1'b0;
        while (expected_times.size() != 0) @(posedge i_clk);
        // Run on after the drain, so that a stray extra result would still be caught.
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### files.f
design/cct_pkg.sv
design/cct_advance.sv
design/calendar_clock_tick_top.sv
sim/calendar_clock_tick_top_test.sv
